>>> sv/rpzp_pkg.sv
// shared types and constants of the rotate, project and depth-test plotter
package rpzp_pkg;

  localparam int SCREEN_WIDTH_DEF  = 80;
  localparam int SCREEN_HEIGHT_DEF = 40;

  // fixed arithmetic widths
  localparam int PW  = 24;  // coefficient times coordinate
  localparam int RW  = 26;  // rotated coordinate
  localparam int ZW  = 27;  // z with camera distance
  localparam int NW  = 39;  // projection numerator
  localparam int QW  = 9;   // projected column or row
  localparam int IXW = 2 * QW;
  localparam int DEPTH_SHIFT = 10;

  localparam logic [15:0] FAR_DEPTH  = 16'hFFFF;
  localparam logic [9:0]  CAM_RST    = 10'd200;
  localparam logic [7:0]  FOCAL_RST  = 8'd80;
  localparam logic [9:0]  HSHIFT_RST = 10'd40;
  localparam logic [7:0]  BG_RST     = 8'd32;

  typedef enum logic [2:0] {
    CFG_ROW_X  = 3'd0,
    CFG_ROW_Y  = 3'd1,
    CFG_ROW_Z  = 3'd2,
    CFG_CAMERA = 3'd3,
    CFG_FOCAL  = 3'd4,
    CFG_HSHIFT = 3'd5,
    CFG_BG     = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_WRITTEN = 2'd0,
    ST_HIDDEN  = 2'd1,
    ST_OFF     = 2'd2,
    ST_READ    = 2'd3
  } status_e;

  typedef enum logic {
    FN_PLOT = 1'b0,
    FN_READ = 1'b1
  } func_e;

  typedef struct packed {
    logic          done;
    logic          off;
    logic [QW-1:0] quot;
  } div_res_t;

endpackage

>>> sv/rpzp_ram.sv
// generic single write port ram with registered read
module rpzp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/rpzp_div.sv
// iterative divider giving a truncated quotient and an off-range flag
module rpzp_div
  import rpzp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [NW-1:0] num_i,
  input  logic signed [ZW-1:0] den_i,
  output div_res_t             res_o
);

  localparam int CW = $clog2(QW + 1);

  logic [ZW-1:0]        rem_q;
  logic [ZW-1:0]        den_q;
  logic [QW-1:0]        low_q;
  logic [QW-1:0]        quot_q;
  logic [CW-1:0]        cnt_q;
  logic                 busy_q, done_q, off_q, neg_q;
  logic signed [NW:0]   sum;
  logic [NW-QW-1:0]     hi;
  logic                 neg, ovf, off;
  logic [ZW:0]          trial;
  logic                 ge;

  assign sum   = (NW+1)'(num_i) + (NW+1)'(den_i);
  assign neg   = num_i[NW-1];
  assign hi    = num_i[NW-1:QW];
  assign ovf   = !neg && (hi >= (NW-QW)'(den_i));
  // a negative numerator is off when the truncated quotient is minus one or less
  assign off   = neg ? (sum <= 0) : ovf;
  assign trial = {rem_q, low_q[QW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW - 1);
        off_q  <= off;
        neg_q  <= neg;
        den_q  <= den_i;
        rem_q  <= ovf ? '0 : num_i[QW+ZW-1:QW];
        low_q  <= num_i[QW-1:0];
        quot_q <= '0;
      end else if (busy_q) begin
        rem_q  <= ge ? ZW'(trial - {1'b0, den_q}) : trial[ZW-1:0];
        low_q  <= {low_q[QW-2:0], 1'b0};
        quot_q <= {quot_q[QW-2:0], ge};
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.off  = off_q;
  assign res_o.quot = neg_q ? '0 : quot_q;

endmodule

>>> sv/rotate_project_zbuffer_plot_unit.sv
// top level: rotate, project and depth-test points into a glyph and depth buffer
//
// input channel s_axis: tuser selects plot or read, tdata carries the point,
// glyph and cell index. output channel m_axis: one result transaction per
// input transaction, tuser is the status, tdata the cell position and glyph.
// configuration writes go through cfg_we_i / cfg_addr_i / cfg_data_i; the
// user must make them only while the block is idle; the block does not enforce it.
// a plot passes through the 9-product rotation, the sums, the projection
// products, the numerators, a shared-step divider per axis (column and row
// in parallel) and a read-modify-write of the two buffers. a point behind
// the camera returns after the numerators, one off screen after the
// dividers. a read skips to the buffer read. one item is in flight at a
// time and the next one is taken the cycle after a result is loaded, so a
// new item waits until the last one has been through all of its steps.
// after reset a clearing pass sweeps every cell (SCREEN_WIDTH*SCREEN_HEIGHT
// cells, 3200 at default size) writing the reset background glyph and far
// depth; s_axis_tready_o stays low meanwhile.
// a result waits in the output register while m_axis_tready_i is low; the
// block accepts the next item and holds its own result until the register
// frees up.
module rotate_project_zbuffer_plot_unit
  import rpzp_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [47:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // point_x[7:0], point_y[15:8], point_z[23:16], glyph[31:24], cell_index[43:32]
  input  logic [47:0] s_axis_tdata_i,
  // func[0]
  input  logic        s_axis_tuser_i,
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // cell_position[11:0], cell_glyph[19:12]
  output logic [23:0] m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]  m_axis_tuser_o
);

  localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam logic signed [10:0] HALF_W = 11'(SCREEN_WIDTH / 2);
  localparam logic signed [8:0]  HALF_H = 9'(SCREEN_HEIGHT / 2);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL, S_SUM, S_PROD, S_NUM, S_START, S_DIV,
    S_ADDR, S_FETCH, S_READ, S_RESULT
  } state_e;

  state_e state_q;

  // configuration registers
  logic [47:0] row_x_q, row_y_q, row_z_q;
  logic [9:0]  cam_q;
  logic [7:0]  foc_q;
  logic [9:0]  hs_q;
  logic [7:0]  bg_q;

  // item registers
  logic              func_q;
  logic signed [7:0] pt_q [3];
  logic [7:0]        glyph_q;

  logic signed [PW-1:0] prod_q [9];
  logic signed [RW-1:0] xr_q, yr_q;
  logic signed [ZW-1:0] z_q;
  logic signed [NW-1:0] pc_q, pk_q, pr_q, pq_q;
  logic signed [NW-1:0] numc_q, numr_q;
  logic                 zle_q;
  logic [15:0]          dq_q;
  logic [QW-1:0]        col_q, row_q;
  logic [AW-1:0]        addr_q;
  logic [11:0]          pos_q;
  logic                 inr_q;
  logic [AW-1:0]        clr_q;

  logic [1:0]  res_st_q;
  logic [11:0] res_pos_q;
  logic [7:0]  res_gly_q;

  logic        out_valid_q;
  logic [1:0]  out_st_q;
  logic [11:0] out_pos_q;
  logic [7:0]  out_gly_q;

  div_res_t    col_res, row_res;

  // memory ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wgly;
  logic [15:0]   ram_wdep;
  logic [7:0]    rd_gly;
  logic [15:0]   rd_dep;

  logic              out_free;
  logic              in_fire;
  logic [IXW-1:0]    idx_full;
  logic [ZW-1:0]     z_shift;
  logic signed [10:0] colofs;
  logic signed [8:0]  ksig;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign colofs   = HALF_W + {hs_q[9], hs_q};
  assign ksig     = $signed({1'b0, foc_q});
  assign idx_full = IXW'(col_q) + IXW'(row_q) * IXW'(SCREEN_WIDTH);
  assign z_shift  = z_q >>> DEPTH_SHIFT;

  // read-modify-write of both buffers (a plot's depth-tested write, or a read clearing its cell), or the clearing sweep
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wgly  = bg_q;
    ram_wdep  = FAR_DEPTH;
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wgly  = BG_RST;
    end else if (state_q == S_READ) begin
      if (func_q == FN_READ) begin
        ram_we = inr_q;
      end else if (dq_q < rd_dep) begin
        ram_we   = 1'b1;
        ram_wgly = glyph_q;
        ram_wdep = dq_q;
      end
    end
  end

  rpzp_ram #(.WIDTH(8), .DEPTH(CELLS)) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wgly),
    .raddr_i (addr_q),
    .rdata_o (rd_gly)
  );

  rpzp_ram #(.WIDTH(16), .DEPTH(CELLS)) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdep),
    .raddr_i (addr_q),
    .rdata_o (rd_dep)
  );

  // column and row dividers run side by side
  rpzp_div u_col_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_START),
    .num_i   (numc_q),
    .den_i   (z_q),
    .res_o   (col_res)
  );

  rpzp_div u_row_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_START),
    .num_i   (numr_q),
    .den_i   (z_q),
    .res_o   (row_res)
  );

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_x_q <= '0;
      row_y_q <= '0;
      row_z_q <= '0;
      cam_q   <= CAM_RST;
      foc_q   <= FOCAL_RST;
      hs_q    <= HSHIFT_RST;
      bg_q    <= BG_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_ROW_X:  row_x_q <= cfg_data_i;
        CFG_ROW_Y:  row_y_q <= cfg_data_i;
        CFG_ROW_Z:  row_z_q <= cfg_data_i;
        CFG_CAMERA: cam_q   <= cfg_data_i[9:0];
        CFG_FOCAL:  foc_q   <= cfg_data_i[7:0];
        CFG_HSHIFT: hs_q    <= cfg_data_i[9:0];
        CFG_BG:     bg_q    <= cfg_data_i[7:0];
        default:    ;
      endcase
    end
  end

  // sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(CELLS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            func_q  <= s_axis_tuser_i;
            pt_q[0] <= s_axis_tdata_i[7:0];
            pt_q[1] <= s_axis_tdata_i[15:8];
            pt_q[2] <= s_axis_tdata_i[23:16];
            glyph_q <= s_axis_tdata_i[31:24];
            addr_q  <= AW'(s_axis_tdata_i[43:32]);
            pos_q   <= s_axis_tdata_i[43:32];
            inr_q   <= IXW'(s_axis_tdata_i[43:32]) < IXW'(CELLS);
            state_q <= (s_axis_tuser_i == FN_READ) ? S_ADDR : S_MUL;
          end
        end
        S_MUL: begin
          for (int i = 0; i < 3; i++) begin
            prod_q[i]     <= $signed(row_x_q[16*i +: 16]) * pt_q[i];
            prod_q[3 + i] <= $signed(row_y_q[16*i +: 16]) * pt_q[i];
            prod_q[6 + i] <= $signed(row_z_q[16*i +: 16]) * pt_q[i];
          end
          state_q <= S_SUM;
        end
        S_SUM: begin
          xr_q <= RW'(prod_q[0]) + RW'(prod_q[1]) + RW'(prod_q[2]);
          yr_q <= RW'(prod_q[3]) + RW'(prod_q[4]) + RW'(prod_q[5]);
          z_q  <= ZW'(prod_q[6]) + ZW'(prod_q[7]) + ZW'(prod_q[8])
                + $signed({3'b000, cam_q, 14'd0});
          state_q <= S_PROD;
        end
        S_PROD: begin
          pc_q  <= colofs * z_q;
          pk_q  <= ksig * xr_q;
          pr_q  <= HALF_H * z_q;
          pq_q  <= ksig * yr_q;
          zle_q <= (z_q <= 0);
          // depth in q12.4, saturated
          dq_q  <= (z_shift > ZW'(FAR_DEPTH)) ? FAR_DEPTH : z_shift[15:0];
          state_q <= S_NUM;
        end
        S_NUM: begin
          numc_q <= pc_q + pk_q;
          numr_q <= pr_q + pq_q;
          if (zle_q) begin
            res_st_q  <= ST_OFF;
            res_pos_q <= '0;
            res_gly_q <= '0;
            state_q   <= S_RESULT;
          end else begin
            state_q <= S_START;
          end
        end
        S_START: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (col_res.done) begin
            col_q <= col_res.quot;
            row_q <= row_res.quot;
            if (col_res.off || row_res.off
                || ({1'b0, col_res.quot} >= (QW+1)'(SCREEN_WIDTH))
                || ({1'b0, row_res.quot} >= (QW+1)'(SCREEN_HEIGHT))) begin
              res_st_q  <= ST_OFF;
              res_pos_q <= '0;
              res_gly_q <= '0;
              state_q   <= S_RESULT;
            end else begin
              state_q <= S_ADDR;
            end
          end
        end
        S_ADDR: begin
          // plots form the cell index here; reads already hold it
          if (func_q == FN_PLOT) begin
            addr_q <= idx_full[AW-1:0];
            pos_q  <= idx_full[11:0];
            state_q <= S_FETCH;
          end else begin
            state_q <= S_READ;
          end
        end
        S_FETCH: begin
          // buffers latch the new address this cycle
          state_q <= S_READ;
        end
        S_READ: begin
          res_pos_q <= pos_q;
          if (func_q == FN_READ) begin
            res_st_q  <= ST_READ;
            res_gly_q <= inr_q ? rd_gly : bg_q;
          end else if (dq_q < rd_dep) begin
            res_st_q  <= ST_WRITTEN;
            res_gly_q <= glyph_q;
          end else begin
            res_st_q  <= ST_HIDDEN;
            res_gly_q <= rd_gly;
          end
          state_q <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            out_st_q    <= res_st_q;
            out_pos_q   <= res_pos_q;
            out_gly_q   <= res_gly_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_st_q;
  assign m_axis_tdata_o  = {4'd0, out_gly_q, out_pos_q};

  // buffers change only in the clearing sweep or the write-back cycle
  a_ram_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CLEAR || state_q == S_READ))
    else $error("buffer written outside write-back");

  // a result leaving the sequencer lands in the output register
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESULT && out_free) |=> m_axis_tvalid_o)
    else $error("result not presented");

  // no item is taken during the clearing sweep
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !s_axis_tready_o)
    else $error("item accepted while clearing");

  // both dividers finish together
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_res.done == row_res.done)
    else $error("dividers out of step");

endmodule
